### src/cpls_pkg.sv
// ----------------------------------------------------------------------------
// cpls_pkg
// Shared constants, types and register indexes of the column projection
// letter segmenter.
// ----------------------------------------------------------------------------
package cpls_pkg;

	// Largest image the block handles
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 256;

	// Position counters and the matching size fields
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int SIZE_W = COL_W + 1;
	localparam int HGT_W  = ROW_W + 1;

	// Configuration register widths and reset values
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 9;
	localparam int CFG_DATA_W   = 11;
	localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
	localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 9'd64;

	// Letter counter
	localparam int INDEX_W = 9;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// One letter box
	typedef struct packed {
		logic [INDEX_W-1:0] letter_index;
		logic [COL_W-1:0]   start_column;
		logic [SIZE_W-1:0]  box_width;
		logic [ROW_W-1:0]   top_row;
		logic [HGT_W-1:0]   box_height;
	} cpls_box_t;

endpackage

### src/cpls_ifs.sv
// ----------------------------------------------------------------------------
// cpls_pix_if / cpls_box_if
// Valid/ready channels of the segmenter: pixels in, letter boxes out.
// ----------------------------------------------------------------------------
interface cpls_pix_if;
	logic valid;
	logic ready;
	logic ink;

	modport source (output valid, output ink, input ready);
	modport sink   (input valid, input ink, output ready);
endinterface

interface cpls_box_if
	import cpls_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] letter_index;
	logic [COL_W-1:0]   start_column;
	logic [SIZE_W-1:0]  box_width;
	logic [ROW_W-1:0]   top_row;
	logic [HGT_W-1:0]   box_height;

	modport source (output valid, output letter_index, output start_column,
		output box_width, output top_row, output box_height, input ready);
	modport sink   (input valid, input letter_index, input start_column,
		input box_width, input top_row, input box_height, output ready);
endinterface

### src/column_projection_letter_segmenter.sv
// ----------------------------------------------------------------------------
// column_projection_letter_segmenter
// Splits a binarised text line, fed column by column, into letter boxes.
// ----------------------------------------------------------------------------
// Pixels enter in column-major order, one per clock with no bubbles while the
// output is not held off: the tracker updates its counters and extents on
// each step, so the sustained rate is one pixel per cycle, and a box leaves
// through the input register, then the result register, after the pixel
// that closes it. A box appears on the last pixel of the first blank column
// after a run, or on the last pixel of the image; counters return to zero
// after each image. Dimensions of zero act as one and oversized ones are
// clamped; write them only while the block is idle.
module column_projection_letter_segmenter
	import cpls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cpls_pix_if.sink              pix,
	cpls_box_if.source            box
);

	logic [CFG_WIDTH_W-1:0]  image_width_q;
	logic [CFG_HEIGHT_W-1:0] image_height_q;
	logic                    valid_s1;
	logic                    ink_s1;
	logic                    valid_s2;
	cpls_box_t               box_s2;
	logic                    adv;
	logic                    step;
	logic                    emit;
	cpls_box_t               box_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH)
				image_width_q <= cfg_data[CFG_WIDTH_W-1:0];
			else if (cfg_index == REG_IMAGE_HEIGHT)
				image_height_q <= cfg_data[CFG_HEIGHT_W-1:0];
		end
	end

	// Result slot frees when empty or taken this cycle
	assign adv       = !valid_s2 || box.ready;
	assign step      = valid_s1 && adv;
	assign pix.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid)
			ink_s1 <= pix.ink;
	end

	cpls_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.ink          (ink_s1),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.emit         (emit),
		.box          (box_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			box_s2 <= box_c;
	end

	// Drive the output channel
	assign box.valid        = valid_s2;
	assign box.letter_index = box_s2.letter_index;
	assign box.start_column = box_s2.start_column;
	assign box.box_width    = box_s2.box_width;
	assign box.top_row      = box_s2.top_row;
	assign box.box_height   = box_s2.box_height;

endmodule

### src/cpls_tracker.sv
// ----------------------------------------------------------------------------
// cpls_tracker
// Position counters, column and run ink extents, and letter box forming.
// One pixel is consumed per step; emit flags a finished box in that step.
// ----------------------------------------------------------------------------
module cpls_tracker
	import cpls_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    ink,
	input  logic [CFG_WIDTH_W-1:0]  image_width,
	input  logic [CFG_HEIGHT_W-1:0] image_height,
	output logic                    emit,
	output cpls_box_t               box
);

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               col_ink_q;
	logic [ROW_W-1:0]   col_top_q;
	logic [ROW_W-1:0]   col_bot_q;
	logic               in_letter_q;
	logic [COL_W-1:0]   run_start_q;
	logic [ROW_W-1:0]   run_top_q;
	logic [ROW_W-1:0]   run_bot_q;
	logic [INDEX_W-1:0] found_q;

	logic [SIZE_W-1:0]  w_eff;
	logic [HGT_W-1:0]   h_eff;
	logic               last_row;
	logic               last_col;
	logic               cink;
	logic [ROW_W-1:0]   ctop;
	logic [ROW_W-1:0]   cbot;
	logic               run_open;
	logic [COL_W-1:0]   rstart;
	logic [ROW_W-1:0]   rtop;
	logic [ROW_W-1:0]   rbot;
	logic               emit_blank;
	logic               emit_end;

	// Clamp the dimensions to their legal range
	always_comb begin
		if (image_width == '0)
			w_eff = SIZE_W'(1);
		else if ({1'b0, image_width} > (CFG_WIDTH_W+1)'(MAX_WIDTH))
			w_eff = SIZE_W'(MAX_WIDTH);
		else
			w_eff = SIZE_W'(image_width);
		if (image_height == '0)
			h_eff = HGT_W'(1);
		else if ({1'b0, image_height} > (CFG_HEIGHT_W+1)'(MAX_HEIGHT))
			h_eff = HGT_W'(MAX_HEIGHT);
		else
			h_eff = HGT_W'(image_height);
	end

	assign last_row = ({1'b0, row_q} + HGT_W'(1)) >= h_eff;
	assign last_col = ({1'b0, col_q} + SIZE_W'(1)) >= w_eff;

	// Fold the current pixel into the column extent
	assign cink = col_ink_q | ink;
	assign ctop = (ink && !col_ink_q) ? row_q : col_top_q;
	assign cbot = ink ? row_q : col_bot_q;

	// Close the column into the run
	always_comb begin
		run_open   = in_letter_q;
		rstart     = run_start_q;
		rtop       = run_top_q;
		rbot       = run_bot_q;
		emit_blank = 1'b0;
		if (last_row) begin
			if (cink) begin
				if (!in_letter_q) begin
					run_open = 1'b1;
					rstart   = col_q;
					rtop     = ctop;
					rbot     = cbot;
				end else begin
					if (ctop < run_top_q)
						rtop = ctop;
					if (cbot > run_bot_q)
						rbot = cbot;
				end
			end else if (in_letter_q) begin
				emit_blank = 1'b1;
				run_open   = 1'b0;
			end
		end
	end

	assign emit_end = last_row && last_col && run_open;
	assign emit     = step && (emit_blank || emit_end);

	// Form the box from the run as it stands after this column
	always_comb begin
		box.letter_index = found_q;
		box.start_column = rstart;
		box.box_width    = SIZE_W'({1'b0, col_q} - {1'b0, rstart})
			+ (emit_end ? SIZE_W'(1) : SIZE_W'(0));
		box.top_row      = rtop;
		box.box_height   = HGT_W'({1'b0, rbot} - {1'b0, rtop} + HGT_W'(1));
	end

	// Advance the counters and extents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			col_ink_q   <= 1'b0;
			col_top_q   <= '1;
			col_bot_q   <= '0;
			in_letter_q <= 1'b0;
			run_start_q <= '0;
			run_top_q   <= '1;
			run_bot_q   <= '0;
			found_q     <= '0;
		end else if (step) begin
			if (!last_row) begin
				row_q     <= row_q + ROW_W'(1);
				col_ink_q <= cink;
				col_top_q <= ctop;
				col_bot_q <= cbot;
			end else if (!last_col) begin
				row_q       <= '0;
				col_q       <= col_q + COL_W'(1);
				col_ink_q   <= 1'b0;
				col_top_q   <= '1;
				col_bot_q   <= '0;
				in_letter_q <= run_open;
				run_start_q <= rstart;
				run_top_q   <= rtop;
				run_bot_q   <= rbot;
				if (emit_blank)
					found_q <= found_q + INDEX_W'(1);
			end else begin
				row_q       <= '0;
				col_q       <= '0;
				col_ink_q   <= 1'b0;
				col_top_q   <= '1;
				col_bot_q   <= '0;
				in_letter_q <= 1'b0;
				run_start_q <= '0;
				run_top_q   <= '1;
				run_bot_q   <= '0;
				found_q     <= '0;
			end
		end
	end

	// Checks
	a_open_run_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		in_letter_q |-> (run_top_q <= run_bot_q))
		else $error("open run has top below bottom");

	a_blank_column_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!col_ink_q |-> (col_top_q == '1 && col_bot_q == '0))
		else $error("blank column carries an ink extent");

	a_box_height_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (box.box_height != '0 && box.box_width != '0))
		else $error("empty letter box");

	a_emit_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !in_letter_q)
		else $error("run still open after its box");

	a_end_of_image_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_row && last_col) |=> (col_q == '0 && found_q == '0))
		else $error("counters kept across images");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the column projection letter segmenter. Pixels are streamed in
// column-major order with random gaps and output back-pressure. An internal
// letter tracker predicts every box, and each box that leaves the block is
// checked field by field. Directed images cover the register extremes, the
// dimension clamps, a size change in the middle of an image, blank images and
// the highest letter index. Then random images, mostly well-formed letters
// with some noise and cut-off images, are run over many image sizes.
// ----------------------------------------------------------------------------
module tb_top
	import cpls_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_PIXELS = 200;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	// Letter tracker and box scoreboard
	class segment_board;
		logic [CFG_WIDTH_W-1:0]  width_reg;
		logic [CFG_HEIGHT_W-1:0] height_reg;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		bit                      col_ink;
		logic [ROW_W-1:0]        col_top;
		logic [ROW_W-1:0]        col_bot;
		bit                      open_run;
		logic [COL_W-1:0]        run_col;
		logic [ROW_W-1:0]        run_top;
		logic [ROW_W-1:0]        run_bot;
		logic [INDEX_W-1:0]      letter_cnt;
		cpls_box_t               pending_boxes[$];
		int                      errors;

		function new();
			width_reg = IMAGE_WIDTH_RST;
			height_reg = IMAGE_HEIGHT_RST;
			errors = 0;
			clear_image();
		endfunction

		function void clear_column();
			col_ink = 1'b0;
			col_top = '1;
			col_bot = '0;
		endfunction

		function void clear_image();
			row = '0;
			col = '0;
			clear_column();
			open_run = 1'b0;
			run_col = '0;
			run_top = '1;
			run_bot = '0;
			letter_cnt = '0;
		endfunction

		function int unsigned clamp_dim(int unsigned v, int unsigned top);
			if (v == 0)
				return 1;
			return (v > top) ? top : v;
		endfunction

		function int unsigned cols();
			return clamp_dim(width_reg, MAX_WIDTH);
		endfunction

		function int unsigned rows();
			return clamp_dim(height_reg, MAX_HEIGHT);
		endfunction

		function bit at_start();
			return row == 0 && col == 0;
		endfunction

		// Pixels still needed to reach the end of the current image
		function int unsigned pixels_left();
			int unsigned h, w, in_col, cols_after;
			h = rows();
			w = cols();
			in_col = (row + 1 < h) ? h - row : 1;
			cols_after = (col + 1 < w) ? w - col - 1 : 0;
			return in_col + cols_after * h;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg = data[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = data[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		endfunction

		// Emit the box of the open run and close it
		function void close_run(int unsigned span);
			cpls_box_t b;
			int unsigned hgt;
			hgt = int'(run_bot) - int'(run_top) + 1;
			b.letter_index = letter_cnt;
			b.start_column = run_col;
			b.box_width = span[SIZE_W-1:0];
			b.top_row = run_top;
			b.box_height = hgt[HGT_W-1:0];
			pending_boxes.push_back(b);
			letter_cnt++;
			open_run = 1'b0;
		endfunction

		// Advance the tracker by one accepted pixel
		function void take_pixel(bit ink);
			int unsigned w, h;
			w = cols();
			h = rows();
			if (ink) begin
				if (!col_ink) begin
					col_ink = 1'b1;
					col_top = row;
				end
				col_bot = row;
			end
			if (row + 1 < h) begin
				row++;
				return;
			end
			// last pixel of the column: merge into the run or close it
			row = '0;
			if (col_ink) begin
				if (!open_run) begin
					open_run = 1'b1;
					run_col = col;
					run_top = col_top;
					run_bot = col_bot;
				end else begin
					if (col_top < run_top)
						run_top = col_top;
					if (col_bot > run_bot)
						run_bot = col_bot;
				end
			end else if (open_run) begin
				close_run(col - run_col);
			end
			clear_column();
			if (col + 1 < w) begin
				col++;
				return;
			end
			// last pixel of the image
			if (open_run)
				close_run(col - run_col + 1);
			clear_image();
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_box(cpls_box_t got);
			cpls_box_t want;
			if (pending_boxes.size() == 0) begin
				$display("%0t: unexpected box, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = pending_boxes.pop_front();
			compare("letter_index", want.letter_index, got.letter_index);
			compare("start_column", want.start_column, got.start_column);
			compare("box_width", want.box_width, got.box_width);
			compare("top_row", want.top_row, got.top_row);
			compare("box_height", want.box_height, got.box_height);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cpls_pix_if pix_ch();
	cpls_box_if box_ch();

	segment_board board = new();
	bit           pix_stream[$];
	bit           tx_calm = 1'b0;
	bit           rx_calm = 1'b0;
	bit           hold_go = 1'b0;
	bit           rx_hold;
	int unsigned  cycles = 0;

	column_projection_letter_segmenter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch.sink),
		.box       (box_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer pixels, idling at random; hold each one until its transfer
	always @(posedge clk) begin
		if (!pix_ch.valid || pix_ch.ready) begin
			if (pix_stream.size() != 0 && (tx_calm || $urandom_range(0, 99) >= 21)) begin
				pix_ch.valid <= 1'b1;
				pix_ch.ink <= pix_stream.pop_front();
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// Feed every pixel transfer to the tracker
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready)
			board.take_pixel(pix_ch.ink);
	end

	// Check box transfers and stall the output at random
	always @(posedge clk) begin
		if (arst_n && box_ch.valid && box_ch.ready)
			board.check_box(cpls_box_t'({box_ch.letter_index, box_ch.start_column,
				box_ch.box_width, box_ch.top_row, box_ch.box_height}));
		box_ch.ready <= !rx_hold && (rx_calm || $urandom_range(0, 99) >= 21);
	end

	// Hold the output off for a long stretch once asked
	initial begin
		rx_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Wait until every pixel has gone in and every box has come out
	task automatic wait_idle();
		while (pix_stream.size() != 0 || pix_ch.valid || board.pending_boxes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_dim(cfg_reg_t idx, int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		board.write_reg(idx, value[CFG_DATA_W-1:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		program_dim(REG_IMAGE_WIDTH, w);
		program_dim(REG_IMAGE_HEIGHT, h);
	endtask

	// One column of height h with ink on rows first..last (none if first > last)
	task automatic push_column(int unsigned h, int unsigned first, int unsigned last);
		for (int unsigned r = 0; r < h; r++)
			pix_stream.push_back(r >= first && r <= last);
	endtask

	task automatic push_random(int unsigned n, int unsigned pct);
		repeat (n) pix_stream.push_back($urandom_range(0, 99) < pct);
	endtask

	// A whole image of letter columns and blank gaps
	task automatic push_letters();
		bit          blank;
		int unsigned pct;
		for (int unsigned c = 0; c < board.cols(); c++) begin
			blank = $urandom_range(0, 99) < 35;
			pct = ($urandom_range(0, 99) < 10) ? 100 : 40;
			for (int unsigned r = 0; r < board.rows(); r++)
				pix_stream.push_back(!blank && $urandom_range(0, 99) < pct);
		end
	endtask

	initial begin
		int unsigned sent, img, w, h, pick, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.ink = 1'b0;
		box_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: two ink columns, then shrink both sizes mid-image so
		// that one blank pixel closes the run and the image together
		push_column(64, 5, 10);
		push_column(64, 63, 63);
		wait_idle();
		set_size(3, 1);
		pix_stream.push_back(1'b0);
		wait_idle();

		// Zero sizes act as one: every pixel is an image
		set_size(0, 0);
		pix_stream.push_back(1'b1);
		pix_stream.push_back(1'b0);
		pix_stream.push_back(1'b1);
		pix_stream.push_back(1'b1);
		wait_idle();

		// Oversized height clamps; box spans the full height, no idling
		set_size(1, 511);
		tx_calm <= 1'b1;
		rx_calm <= 1'b1;
		push_column(MAX_HEIGHT, 0, MAX_HEIGHT - 1);
		wait_idle();
		tx_calm <= 1'b0;
		rx_calm <= 1'b0;

		// Shrink both sizes mid-image, the height below the current row
		set_size(8, 8);
		push_random(13, 100);
		wait_idle();
		set_size(2, 3);
		push_random(board.pixels_left(), 50);
		wait_idle();

		// Blank image gives no box
		set_size(3, 2);
		push_random(6, 0);
		wait_idle();

		// Back-pressure: the output holds off while pixels keep coming; the
		// oversized width clamps and one-column letters reach the highest index
		set_size(2047, 1);
		tx_calm <= 1'b1;
		hold_go = 1'b1;
		for (int unsigned c = 0; c < MAX_WIDTH; c++)
			pix_stream.push_back(c % 2 == 1);
		wait_idle();
		tx_calm <= 1'b0;

		// Random images, mostly well-formed letters
		sent = 0;
		img = 0;
		while (sent < RANDOM_PIXELS) begin
			wait_idle();
			pick = $urandom_range(0, 99);
			w = $urandom_range(1, 20);
			h = $urandom_range(1, 8);
			if (pick < 4) begin
				w = 0;
			end else if (pick < 8) begin
				h = 0;
			end else if (pick < 10) begin
				w = $urandom_range(1, 2);
				h = $urandom_range(257, 511);
			end else if (pick < 12) begin
				w = $urandom_range(1025, 2047);
				h = 1;
			end
			set_size(w, h);
			pick = $urandom_range(0, 99);
			n = board.pixels_left();
			if (pick < 10) begin
				// cut-off image: may leave the tracker mid-image
				n = $urandom_range(1, 60);
				push_random(n, 50);
			end else if (!board.at_start() || pick < 20) begin
				push_random(n, 30);
			end else begin
				n = board.cols() * board.rows();
				push_letters();
			end
			sent += n;
			img++;
		end
		tx_calm <= 1'b0;
		rx_calm <= 1'b0;
		wait_idle();

		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
src/cpls_pkg.sv
src/cpls_ifs.sv
src/cpls_tracker.sv
src/column_projection_letter_segmenter.sv
sim/tb_top.sv
